// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  `ASSERT_CLK(lbl, clk, rst_n, !(expr))

`endif

// ===== sv/oat_pkg.sv =====
package oat_pkg;

  // table geometry (capacity must be a power of two)
  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int FILL_W   = $clog2(CAPACITY + 1);

  // word field widths
  localparam int KIND_W  = 2;
  localparam int KEY_W   = 32;
  localparam int HASH_W  = 32;
  localparam int VALUE_W = 64;
  localparam int LIMIT_W = 9;

  // configuration
  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = LIMIT_W'(192);

  // operation codes
  localparam logic [KIND_W-1:0] KIND_GET = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEL = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_COMMIT,
    ST_RESP
  } oat_state_t;

  // request from the sequencer to the slot store
  typedef struct packed {
    logic             rd;
    logic             put;
    logic             kill;
    logic [IDX_W-1:0] addr;
  } slot_req_t;

  // registered slot contents returned by the store
  typedef struct packed {
    logic               used;
    logic               tomb;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } slot_rsp_t;

endpackage

// ===== sv/oat_slots.sv =====
module oat_slots (
  input  logic                       clk,
  input  logic                       rst_n,
  input  oat_pkg::slot_req_t         req,
  input  logic [oat_pkg::KEY_W-1:0]   wr_key,
  input  logic [oat_pkg::VALUE_W-1:0] wr_value,
  output oat_pkg::slot_rsp_t         rsp
);
  import oat_pkg::*;

  // flag bits per slot, cleared at reset
  logic [CAPACITY-1:0] used_r;
  logic [CAPACITY-1:0] tomb_r;

  // key and value memories, contents only read behind a used flag
  logic [KEY_W-1:0]   key_mem   [CAPACITY];
  logic [VALUE_W-1:0] value_mem [CAPACITY];

  slot_rsp_t rsp_r;

  // flag updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      tomb_r <= '0;
    end else if (req.put) begin
      used_r[req.addr] <= 1'b1;
      tomb_r[req.addr] <= 1'b0;
    end else if (req.kill) begin
      used_r[req.addr] <= 1'b0;
      tomb_r[req.addr] <= 1'b1;
    end
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (req.put) begin
      key_mem[req.addr]   <= wr_key;
      value_mem[req.addr] <= wr_value;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.rd) begin
      rsp_r.used  <= used_r[req.addr];
      rsp_r.tomb  <= tomb_r[req.addr];
      rsp_r.key   <= key_mem[req.addr];
      rsp_r.value <= value_mem[req.addr];
    end
  end

  assign rsp = rsp_r;

endmodule

// ===== sv/oat_ctrl.sv =====
module oat_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  // input word
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [oat_pkg::KIND_W-1:0]  in_kind,
  input  logic [oat_pkg::KEY_W-1:0]   in_key,
  input  logic [oat_pkg::HASH_W-1:0]  in_hash,
  input  logic [oat_pkg::VALUE_W-1:0] in_value,
  input  logic [oat_pkg::LIMIT_W-1:0] load_limit,
  // slot store
  output oat_pkg::slot_req_t          req,
  output logic [oat_pkg::KEY_W-1:0]   wr_key,
  output logic [oat_pkg::VALUE_W-1:0] wr_value,
  input  oat_pkg::slot_rsp_t          rsp,
  // result word
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic [oat_pkg::VALUE_W-1:0] out_value,
  output logic                        out_status
);
  import oat_pkg::*;

  oat_state_t state_r, state_nxt;

  logic [KIND_W-1:0]  kind_r;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] value_r;
  logic [IDX_W-1:0]   pos_r;
  logic [IDX_W-1:0]   probe_cnt_r;
  logic               have_tomb_r;
  logic [IDX_W-1:0]   tomb_pos_r;
  logic [IDX_W-1:0]   where_r;
  logic               was_used_r;
  logic               grow_r;
  logic [FILL_W-1:0]  fill_r;
  logic               hit_r;
  logic [VALUE_W-1:0] rd_value_r;
  logic               status_r;

  logic               accept;
  logic               empty_tbl;
  logic               over_limit;
  logic               early_end;
  logic               match;
  logic               is_empty;
  logic               is_tomb;
  logic               last;
  logic               tomb_seen;
  logic [IDX_W-1:0]   tomb_at;
  logic               cmp_hit_get;
  logic               cmp_commit;
  logic               cmp_fail_set;
  logic               cmp_end;
  logic [IDX_W-1:0]   commit_addr;
  logic [IDX_W-1:0]   pos_next;

  assign accept = in_valid && in_ready;

  // checks made at accept time
  always_comb begin
    empty_tbl  = (fill_r == '0);
    over_limit = ({1'b0, fill_r} + (FILL_W + 1)'(1)) > (FILL_W + 1)'(load_limit);
    case (in_kind)
      KIND_GET: early_end = empty_tbl;
      KIND_SET: early_end = over_limit;
      KIND_DEL: early_end = empty_tbl;
      default:  early_end = 1'b1;
    endcase
  end

  // shared slot compare
  always_comb begin
    match     = rsp.used && (rsp.key == key_r);
    is_empty  = !rsp.used && !rsp.tomb;
    is_tomb   = !rsp.used && rsp.tomb;
    last      = (probe_cnt_r == IDX_W'(CAPACITY - 1));
    tomb_seen = have_tomb_r || is_tomb;
    tomb_at   = have_tomb_r ? tomb_pos_r : pos_r;
    cmp_hit_get  = match && (kind_r == KIND_GET);
    cmp_commit   = ((kind_r == KIND_SET) && (match || is_empty || (last && tomb_seen))) ||
                   ((kind_r == KIND_DEL) && match);
    cmp_fail_set = (kind_r == KIND_SET) && !match && !is_empty && last && !tomb_seen;
    cmp_end      = match || is_empty || last;
    commit_addr  = match ? pos_r : tomb_at;
    pos_next     = (pos_r == IDX_W'(CAPACITY - 1)) ? '0 : pos_r + 1'b1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = early_end ? ST_RESP : ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (cmp_commit) begin
          state_nxt = ST_COMMIT;
        end else if (cmp_end) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_COMMIT: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and store requests
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_RESP);
    req.rd    = (state_r == ST_RD);
    req.put   = (state_r == ST_COMMIT) && (kind_r == KIND_SET);
    req.kill  = (state_r == ST_COMMIT) && (kind_r == KIND_DEL);
    req.addr  = (state_r == ST_COMMIT) ? where_r : pos_r;
  end

  assign wr_key     = key_r;
  assign wr_value   = value_r;
  assign out_hit    = hit_r;
  assign out_value  = rd_value_r;
  assign out_status = status_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_COMMIT) && (kind_r == KIND_SET) && grow_r) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  // probe datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          kind_r      <= in_kind;
          key_r       <= in_key;
          value_r     <= in_value;
          pos_r       <= IDX_W'(in_hash % CAPACITY);
          probe_cnt_r <= '0;
          have_tomb_r <= 1'b0;
          hit_r       <= 1'b0;
          rd_value_r  <= '0;
          status_r    <= (in_kind == KIND_SET) && over_limit;
        end
      end
      ST_CMP: begin
        if (is_tomb && !have_tomb_r) begin
          have_tomb_r <= 1'b1;
          tomb_pos_r  <= pos_r;
        end
        if (cmp_hit_get) begin
          hit_r      <= 1'b1;
          rd_value_r <= rsp.value;
        end
        if (cmp_fail_set) begin
          status_r <= 1'b1;
        end
        where_r    <= commit_addr;
        was_used_r <= match;
        grow_r     <= is_empty && !have_tomb_r;
        if (!cmp_end) begin
          pos_r       <= pos_next;
          probe_cnt_r <= probe_cnt_r + 1'b1;
        end
      end
      ST_COMMIT: begin
        if (kind_r == KIND_SET) begin
          hit_r <= !was_used_r;
        end else begin
          hit_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/open_addressing_hash_table.sv =====
// Key/value table of 256 slots with linear probing and tombstones. Each input word is one
// operation (get, set or delete) and yields exactly one result word. The slot flags are
// cleared at reset. Steps: the word is accepted, then each slot probed takes a read of the
// single-port slot store followed by a key compare, a set or delete that writes a slot adds
// a write step, and the result then waits in the output register until taken. A get or
// delete on an empty table, a set refused by the load limit and an unused operation code
// answer without probing the store. No new word is accepted until the result word has been
// taken.
module open_addressing_hash_table (
  input  logic         clk,
  input  logic         rst_n,
  // input word
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // key_handle[31:0], key_hash[63:32], new_value[127:64]
  input  logic [1:0]   in_tuser,  // kind[1:0]
  // result word
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata, // hit[0], read_value[64:1], status[65], zero[71:66]
  // configuration
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import oat_pkg::*;

  logic [LIMIT_W-1:0] load_limit_r;
  logic               cfg_wr;
  logic               cfg_sel_limit;

  slot_req_t          req;
  slot_rsp_t          rsp;
  logic [KEY_W-1:0]   wr_key;
  logic [VALUE_W-1:0] wr_value;

  logic               res_hit;
  logic [VALUE_W-1:0] res_value;
  logic               res_status;

  // configuration register
  assign cfg_pready    = 1'b1;
  assign cfg_sel_limit = (cfg_paddr[2] == 1'b0);
  assign cfg_wr        = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_limit_r <= LOAD_LIMIT_RESET;
    end else if (cfg_wr && cfg_sel_limit) begin
      load_limit_r <= cfg_pwdata[LIMIT_W-1:0];
    end
  end

  assign cfg_prdata = cfg_sel_limit ? {{(32 - LIMIT_W){1'b0}}, load_limit_r} : '0;

  // probe sequencer
  oat_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (in_tuser),
    .in_key     (in_tdata[31:0]),
    .in_hash    (in_tdata[63:32]),
    .in_value   (in_tdata[127:64]),
    .load_limit (load_limit_r),
    .req        (req),
    .wr_key     (wr_key),
    .wr_value   (wr_value),
    .rsp        (rsp),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_hit    (res_hit),
    .out_value  (res_value),
    .out_status (res_status)
  );

  // slot store
  oat_slots u_slots (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .wr_key   (wr_key),
    .wr_value (wr_value),
    .rsp      (rsp)
  );

  // result word packing
  assign out_tdata = {6'b0, res_status, res_value, res_hit};

endmodule

// ===== sv/oat_checker.sv =====
`include "assert_macros.svh"

module oat_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [71:0]  out_tdata
);

  logic        res_hit;
  logic [63:0] res_value;
  logic        res_status;
  logic        out_wait;

  // result word fields
  assign res_hit    = out_tdata[0];
  assign res_value  = out_tdata[64:1];
  assign res_status = out_tdata[65];
  assign out_wait   = out_tvalid && !out_tready;

  // a pending result holds still until taken
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_wait |=> out_tvalid && $stable(out_tdata))

  // one operation at a time: no new word while a result waits
  `ASSERT_NEVER(a_no_overlap, clk, rst_n, in_tready && out_tvalid)

  // an accepted word closes the input side
  `ASSERT_CLK(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready |=> !in_tready)

  // a refused set reports no hit and no value
  `ASSERT_CLK(a_refuse_clean, clk, rst_n, out_tvalid && res_status |-> !res_hit && (res_value == 64'd0))

  // a value is only returned with a hit
  `ASSERT_CLK(a_value_needs_hit, clk, rst_n, out_tvalid && (res_value != 64'd0) |-> res_hit)

endmodule

bind open_addressing_hash_table oat_checker u_oat_checker (.*);
